// ===== rtl/core/arpl_pkg.sv =====
// arpl_pkg: shared types and constants of the arp ip-to-mac learning table
// used by arpl_ctrl, arpl_dpath, the top level and the port checker
// depends on nothing
package arpl_pkg;

	// ethertype of an arp frame
	localparam logic [15:0] ARP_FRAME_TYPE = 16'h0806;

	// fixed widths of the result fields
	localparam int SLOT_W  = 6;
	localparam int COUNT_W = 7;

	// per-pair learning outcome
	typedef enum logic [1:0] {
		ST_IGNORED = 2'd0,
		ST_UPDATED = 2'd1,
		ST_ADDED   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;    // load the input item, clear results
		logic sel_tgt;    // work on the target pair
		logic scan_init;  // restart the table scan
		logic scan_en;    // issue the next table read
		logic upd_hit;    // overwrite mac of the matching slot
		logic add_new;    // append the pair at the next free slot
		logic rec_full;   // record table full for the pair
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_arp;     // captured item is an arp frame
		logic mac_zero;   // selected pair carries an all-zero mac
		logic hit;        // read data of the scan matches the pair ip
		logic scan_done;  // all valid slots read, none in flight
		logic full;       // no free slot left
	} dp_stat_t;

endpackage

// ===== rtl/core/arp_ip_mac_learning_table.sv =====
// arp_ip_mac_learning_table: arp snooping table that learns ip-to-mac bindings
// top level, joins arpl_ctrl and arpl_dpath
// depends on arpl_pkg, arpl_ctrl, arpl_dpath
//
// channel   | handshake        | payload
// ----------+------------------+-----------------------------------------------
// frame in  | start, busy      | eth_type, sender_ip/mac, target_ip/mac
// result    | done (strobe)    | sender_status/slot, target_status/slot,
//           |                  | entry_count
//
// one item at a time: an item is taken when start is high and busy is low
// each pair scans the valid slots through the single ip memory read port,
// one slot a cycle, and stops at the first slot whose ip matches the pair
// done is high for one cycle with busy already low, so start may follow at once
// reset clears the entry count, scan state and controller; table contents
// need no clearing pass
// the receiver cannot stall: results are shown for the done cycle and held
// until the next item is taken
module arp_ip_mac_learning_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [15:0]                   eth_type,
	input  logic [31:0]                   sender_ip,
	input  logic [47:0]                   sender_mac,
	input  logic [31:0]                   target_ip,
	input  logic [47:0]                   target_mac,
	output logic                          done,
	output logic [1:0]                    sender_status,
	output logic [arpl_pkg::SLOT_W-1:0]   sender_slot,
	output logic [1:0]                    target_status,
	output logic [arpl_pkg::SLOT_W-1:0]   target_slot,
	output logic [arpl_pkg::COUNT_W-1:0]  entry_count
);

	// command and status between controller and datapath
	arpl_pkg::dp_cmd_t  cmd;
	arpl_pkg::dp_stat_t stat;

	// controller: sender pair first, then target pair, so the
	// target scan sees whatever the sender update left behind
	arpl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: memories, count, scan pointer, results
	arpl_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.eth_type      (eth_type),
		.sender_ip     (sender_ip),
		.sender_mac    (sender_mac),
		.target_ip     (target_ip),
		.target_mac    (target_mac),
		.sender_status (sender_status),
		.sender_slot   (sender_slot),
		.target_status (target_status),
		.target_slot   (target_slot),
		.entry_count   (entry_count)
	);

endmodule

// ===== rtl/core/arpl_ctrl.sv =====
// arpl_ctrl: controller state machine of the learning table
// sequences sender pair then target pair through scan and update
// depends on arpl_pkg
module arpl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  arpl_pkg::dp_stat_t stat,
	output arpl_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PAIR,
		S_SCAN
	} state_t;

	state_t state_q;
	logic   tgt_q;
	logic   done_q;
	logic   pair_end;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		cmd          = '0;
		cmd.sel_tgt  = tgt_q;
		pair_end     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = start;
			end
			S_PAIR: begin
				if (!stat.is_arp || stat.mac_zero) begin
					pair_end = 1'b1;
				end else begin
					cmd.scan_init = 1'b1;
				end
			end
			S_SCAN: begin
				priority if (stat.hit) begin
					cmd.upd_hit = 1'b1;
					pair_end    = 1'b1;
				end else if (stat.scan_done) begin
					cmd.rec_full = stat.full;
					cmd.add_new  = !stat.full;
					pair_end     = 1'b1;
				end else begin
					cmd.scan_en = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tgt_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_PAIR;
						tgt_q   <= 1'b0;
					end
				end
				S_PAIR, S_SCAN: begin
					if (pair_end) begin
						if (tgt_q) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= S_PAIR;
							tgt_q   <= 1'b1;
						end
					end else if (state_q == S_PAIR) begin
						state_q <= S_SCAN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/arpl_dpath.sv =====
// arpl_dpath: datapath of the learning table
// holds the ip and mac memories, entry count, scan pointer and result registers
// depends on arpl_pkg
module arpl_dpath #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  arpl_pkg::dp_cmd_t             cmd,
	output arpl_pkg::dp_stat_t            stat,
	input  logic [15:0]                   eth_type,
	input  logic [31:0]                   sender_ip,
	input  logic [47:0]                   sender_mac,
	input  logic [31:0]                   target_ip,
	input  logic [47:0]                   target_mac,
	output logic [1:0]                    sender_status,
	output logic [arpl_pkg::SLOT_W-1:0]   sender_slot,
	output logic [1:0]                    target_status,
	output logic [arpl_pkg::SLOT_W-1:0]   target_slot,
	output logic [arpl_pkg::COUNT_W-1:0]  entry_count
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// table memories, undefined until written
	logic [31:0] ip_mem  [TABLE_DEPTH];
	logic [47:0] mac_mem [TABLE_DEPTH];

	// captured item
	logic        arp_q;
	logic [31:0] snd_ip_q;
	logic [47:0] snd_mac_q;
	logic [31:0] tgt_ip_q;
	logic [47:0] tgt_mac_q;

	// control state
	logic [CW-1:0] used_q;
	logic [CW-1:0] ptr_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [31:0]   rd_ip_s1;

	// results
	arpl_pkg::status_t           s_status_q;
	arpl_pkg::status_t           t_status_q;
	logic [arpl_pkg::SLOT_W-1:0] s_slot_q;
	logic [arpl_pkg::SLOT_W-1:0] t_slot_q;

	logic [31:0]                 cur_ip;
	logic [47:0]                 cur_mac;
	logic                        rd_issue;
	logic                        rec;
	arpl_pkg::status_t           rec_status;
	logic [arpl_pkg::SLOT_W-1:0] rec_slot;

	assign cur_ip   = cmd.sel_tgt ? tgt_ip_q  : snd_ip_q;
	assign cur_mac  = cmd.sel_tgt ? tgt_mac_q : snd_mac_q;
	assign rd_issue = cmd.scan_en && (ptr_q < used_q);

	assign stat.is_arp    = arp_q;
	assign stat.mac_zero  = (cur_mac == '0);
	assign stat.hit       = rd_vld_s1 && (rd_ip_s1 == cur_ip);
	assign stat.scan_done = (ptr_q >= used_q) && !rd_vld_s1;
	assign stat.full      = (used_q >= DEPTH_C);

	assign rec = cmd.upd_hit || cmd.add_new || cmd.rec_full;

	always_comb begin
		priority if (cmd.upd_hit) begin
			rec_status = arpl_pkg::ST_UPDATED;
			rec_slot   = arpl_pkg::SLOT_W'(rd_idx_s1);
		end else if (cmd.add_new) begin
			rec_status = arpl_pkg::ST_ADDED;
			rec_slot   = arpl_pkg::SLOT_W'(used_q);
		end else begin
			rec_status = arpl_pkg::ST_FULL;
			rec_slot   = '0;
		end
	end

	// memory writes and registered read
	always_ff @(posedge clk) begin
		if (cmd.upd_hit) begin
			mac_mem[rd_idx_s1] <= cur_mac;
		end
		if (cmd.add_new) begin
			ip_mem[used_q[IW-1:0]]  <= cur_ip;
			mac_mem[used_q[IW-1:0]] <= cur_mac;
		end
		if (rd_issue) begin
			rd_ip_s1  <= ip_mem[ptr_q[IW-1:0]];
			rd_idx_s1 <= ptr_q[IW-1:0];
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			arp_q      <= (eth_type == arpl_pkg::ARP_FRAME_TYPE);
			snd_ip_q   <= sender_ip;
			snd_mac_q  <= sender_mac;
			tgt_ip_q   <= target_ip;
			tgt_mac_q  <= target_mac;
			s_status_q <= arpl_pkg::ST_IGNORED;
			t_status_q <= arpl_pkg::ST_IGNORED;
			s_slot_q   <= '0;
			t_slot_q   <= '0;
		end else if (rec) begin
			if (cmd.sel_tgt) begin
				t_status_q <= rec_status;
				t_slot_q   <= rec_slot;
			end else begin
				s_status_q <= rec_status;
				s_slot_q   <= rec_slot;
			end
		end
	end

	// count, scan pointer and read valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.add_new) begin
				used_q <= used_q + CW'(1);
			end
			if (cmd.scan_init) begin
				ptr_q     <= '0;
				rd_vld_s1 <= 1'b0;
			end else begin
				rd_vld_s1 <= rd_issue;
				if (rd_issue) begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
		end
	end

	assign sender_status = s_status_q;
	assign sender_slot   = s_slot_q;
	assign target_status = t_status_q;
	assign target_slot   = t_slot_q;
	assign entry_count   = arpl_pkg::COUNT_W'(used_q);

endmodule

// ===== rtl/core/arpl_checker.sv =====
// arpl_checker: port-level checks of the learning table
// bound to arp_ip_mac_learning_table at the end of this file
// depends on arpl_pkg
module arpl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [1:0]                    sender_status,
	input logic [1:0]                    target_status,
	input logic [arpl_pkg::COUNT_W-1:0]  entry_count
);

	// a taken item makes the block busy
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item taken but block not busy");

	// the result strobe never overlaps a busy cycle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// every finished item shows its result strobe as busy falls
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("item finished without result");

	// a full table on the sender pair leaves no room for the target pair
	a_full_no_add: assert property (@(posedge clk) disable iff (!arst_n)
		done && (sender_status == arpl_pkg::ST_FULL)
			|-> (target_status != arpl_pkg::ST_ADDED))
		else $error("target added after sender found table full");

	// the entry count only moves while an item is being worked on
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> $stable(entry_count))
		else $error("entry count changed while idle");

endmodule

bind arp_ip_mac_learning_table arpl_checker u_arpl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.sender_status (sender_status),
	.target_status (target_status),
	.entry_count   (entry_count)
);

// ===== test/tb_top.sv =====
// tb_top: self-checking regression of arp_ip_mac_learning_table, scoreboard driven
// sends directed and random frames through start/busy and checks every done strobe
// depends on arpl_pkg and the arp_ip_mac_learning_table rtl
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = 64;
	localparam int CYCLE_LIMIT  = 2_000_000;  // only reached if the block hangs
	localparam int TAIL_CYCLES  = 140;        // idle tail after the last test, before the final check
	localparam int POOL_SIZE    = 96;
	localparam int IDLE_PCT     = 17;
	localparam int MAX_REPORTS  = 40;

	// what one frame should produce on the result ports
	typedef struct {
		arpl_pkg::status_t                 sender_status;
		logic [arpl_pkg::SLOT_W-1:0]       sender_slot;
		arpl_pkg::status_t                 target_status;
		logic [arpl_pkg::SLOT_W-1:0]       target_slot;
		logic [arpl_pkg::COUNT_W-1:0]      entry_count;
	} learn_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// frame side, known from time zero
	logic        start      = 1'b0;
	logic [15:0] eth_type   = '0;
	logic [31:0] sender_ip  = '0;
	logic [47:0] sender_mac = '0;
	logic [31:0] target_ip  = '0;
	logic [47:0] target_mac = '0;

	// result side
	logic                          busy;
	logic                          done;
	logic [1:0]                    sender_status;
	logic [arpl_pkg::SLOT_W-1:0]   sender_slot;
	logic [1:0]                    target_status;
	logic [arpl_pkg::SLOT_W-1:0]   target_slot;
	logic [arpl_pkg::COUNT_W-1:0]  entry_count;

	arp_ip_mac_learning_table #(.TABLE_DEPTH(DEPTH)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.eth_type      (eth_type),
		.sender_ip     (sender_ip),
		.sender_mac    (sender_mac),
		.target_ip     (target_ip),
		.target_mac    (target_mac),
		.done          (done),
		.sender_status (sender_status),
		.sender_slot   (sender_slot),
		.target_status (target_status),
		.target_slot   (target_slot),
		.entry_count   (entry_count)
	);

	always #5ns clk = ~clk;

	// shadow of the learned bindings, slots 0..bound_count-1 are valid
	logic [31:0] bound_ip  [DEPTH];
	logic [47:0] bound_mac [DEPTH];
	int          bound_count;

	// outcomes of accepted frames, oldest first
	learn_result_t pending_results[$];

	// candidate addresses for the random phases, a small set gives many hits
	logic [31:0] ip_pool [POOL_SIZE];

	bit idle_on = 1'b1;
	int fail_count;
	int frames_sent;
	int results_seen;
	int status_tally [4];
	int cycle_count;

	// ---------------------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------------------

	// learn one ip/mac pair into the shadow table, first matching slot wins
	function automatic void learn_pair(input logic [31:0] ip, input logic [47:0] mac,
			output arpl_pkg::status_t st, output logic [arpl_pkg::SLOT_W-1:0] slot);
		int hit;
		st   = arpl_pkg::ST_IGNORED;
		slot = '0;
		hit  = -1;
		if (mac != '0) begin
			for (int i = 0; i < bound_count; i++)
				if (hit < 0 && bound_ip[i] == ip)
					hit = i;
			if (hit >= 0) begin
				bound_mac[hit] = mac;
				st             = arpl_pkg::ST_UPDATED;
				slot           = arpl_pkg::SLOT_W'(hit);
			end else if (bound_count >= DEPTH) begin
				// no room, the pair is lost
				st = arpl_pkg::ST_FULL;
			end else begin
				bound_ip[bound_count]  = ip;
				bound_mac[bound_count] = mac;
				slot                   = arpl_pkg::SLOT_W'(bound_count);
				bound_count++;
				st = arpl_pkg::ST_ADDED;
			end
		end
		status_tally[int'(st)]++;
	endfunction

	// sender first, target second, so the target sees the sender's update
	function automatic learn_result_t predict_frame(input logic [15:0] et,
			input logic [31:0] sip, input logic [47:0] smac,
			input logic [31:0] tip, input logic [47:0] tmac);
		learn_result_t r;
		r.sender_status = arpl_pkg::ST_IGNORED;
		r.sender_slot   = '0;
		r.target_status = arpl_pkg::ST_IGNORED;
		r.target_slot   = '0;
		if (et == arpl_pkg::ARP_FRAME_TYPE) begin
			learn_pair(sip, smac, r.sender_status, r.sender_slot);
			learn_pair(tip, tmac, r.target_status, r.target_slot);
		end
		r.entry_count = arpl_pkg::COUNT_W'(bound_count);
		return r;
	endfunction

	// ---------------------------------------------------------------------------
	// driving
	// ---------------------------------------------------------------------------

	// present one frame and hold it until an edge with busy low takes it
	// start is left high on return, so a following frame goes back to back
	task automatic send_frame(input logic [15:0] et, input logic [31:0] sip,
			input logic [47:0] smac, input logic [31:0] tip, input logic [47:0] tmac);
		// idle only on cycles where the block could take a frame
		if (idle_on) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				start <= 1'b0;
				do @(posedge clk); while (busy);
			end
		end
		start      <= 1'b1;
		eth_type   <= et;
		sender_ip  <= sip;
		sender_mac <= smac;
		target_ip  <= tip;
		target_mac <= tmac;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_frame(et, sip, smac, tip, tmac));
		frames_sent++;
	endtask

	// drop start and hold off until every outstanding result has come back
	task automatic settle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// mostly random macs, some all-zero ones and some all-ones ones
	function automatic logic [47:0] random_mac();
		int pick;
		pick = $urandom_range(99);
		if (pick < 6)
			return '0;
		if (pick < 8)
			return '1;
		return 48'({$urandom(), $urandom()});
	endfunction

	// an address from the first span pool entries, or a fresh one now and then
	function automatic logic [31:0] pick_ip(input int span, input int fresh_pct);
		if ($urandom_range(99) < fresh_pct)
			return $urandom();
		return ip_pool[$urandom_range(span - 1)];
	endfunction

	// one random frame, mostly well-formed arp with some noise mixed in
	task automatic random_frame(input int span, input int fresh_pct);
		int          kind;
		logic [15:0] et;
		logic [31:0] sip;
		logic [31:0] tip;
		kind = $urandom_range(99);
		et   = arpl_pkg::ARP_FRAME_TYPE;
		if (kind < 8)
			et = 16'($urandom());
		else if (kind < 13)
			et = arpl_pkg::ARP_FRAME_TYPE ^ (16'h1 << $urandom_range(15));  // near miss
		sip = pick_ip(span, fresh_pct);
		tip = pick_ip(span, fresh_pct);
		if ($urandom_range(99) < 10)
			tip = sip;  // gratuitous-style, same ip twice in one frame
		send_frame(et, sip, random_mac(), tip, random_mac());
	endtask

	// ---------------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------------

	// extremes and every special case, starting from an empty table
	task automatic test_directed();
		// frames that are not arp change nothing
		send_frame(16'h0800, 32'h0a000001, 48'h0011_2233_4455, 32'h0a000002, 48'h1);
		send_frame(16'h0000, 32'h0a000001, 48'h0011_2233_4455, 32'h0a000002, 48'h1);
		send_frame(16'hffff, 32'h0a000001, 48'h0011_2233_4455, 32'h0a000002, 48'h1);
		send_frame(16'h0807, 32'h0a000001, 48'h0011_2233_4455, 32'h0a000002, 48'h1);
		send_frame(16'h8806, 32'h0a000001, 48'h0011_2233_4455, 32'h0a000002, 48'h1);
		// first entries at the address extremes
		send_frame(arpl_pkg::ARP_FRAME_TYPE, 32'h0, '1, 32'hffff_ffff, 48'h1);
		// all-zero macs are ignored on both sides
		send_frame(arpl_pkg::ARP_FRAME_TYPE, 32'h0a000003, '0, 32'h0a000004, '0);
		// zero mac on the sender only, target is added
		send_frame(arpl_pkg::ARP_FRAME_TYPE, 32'h0a000005, '0, 32'h0a000006,
				48'h0200_0000_0006);
		// known sender gets a new mac, zero mac on the target
		send_frame(arpl_pkg::ARP_FRAME_TYPE, 32'h0, 48'h8000_0000_0000, 32'h0a000007, '0);
		// unknown ip twice in one frame, added then overwritten in place
		send_frame(arpl_pkg::ARP_FRAME_TYPE, 32'hc0a8_0101, 48'h0a0b_0c0d_0e0f,
				32'hc0a8_0101, 48'h1a1b_1c1d_1e1f);
		// known ip twice in one frame
		send_frame(arpl_pkg::ARP_FRAME_TYPE, 32'hffff_ffff, 48'h0000_0000_0002,
				32'hffff_ffff, 48'hffff_ffff_fffe);
		// alternating bit patterns
		send_frame(arpl_pkg::ARP_FRAME_TYPE, 32'ha5a5_a5a5, 48'haaaa_aaaa_aaaa,
				32'h5a5a_5a5a, 48'h5555_5555_5555);
		// non-arp carrying a known ip leaves it alone
		send_frame(16'h86dd, 32'ha5a5_a5a5, 48'h1234_5678_9abc, 32'h0, 48'h1);
		// zero mac with an unknown ip is not added
		send_frame(arpl_pkg::ARP_FRAME_TYPE, 32'h0b0b_0b0b, '0, 32'h0c0c_0c0c, '0);
		// both known, swapped roles
		send_frame(arpl_pkg::ARP_FRAME_TYPE, 32'h5a5a_5a5a, 48'h0000_ffff_0000,
				32'ha5a5_a5a5, 48'hffff_0000_ffff);
		settle();
	endtask

	// random frames over a pool that widens, so the table grows gradually
	task automatic test_growing_table();
		for (int i = 0; i < 700; i++)
			random_frame(4 + (i * 56) / 700, 0);
		settle();
	endtask

	// no idling at all on the sender side
	task automatic test_back_to_back();
		idle_on = 1'b0;
		for (int i = 0; i < 300; i++)
			random_frame(64, 2);
		settle();
		idle_on = 1'b1;
	endtask

	// fill every slot, then new, known and mixed pairs against the full table
	task automatic test_table_limit();
		while (bound_count < DEPTH)
			send_frame(arpl_pkg::ARP_FRAME_TYPE, $urandom(), {16'h0200, 32'($urandom())},
					$urandom(), {16'h0600, 32'($urandom())});
		send_frame(arpl_pkg::ARP_FRAME_TYPE, 32'h7f00_0001, 48'h1, 32'h7f00_0002, 48'h2);
		send_frame(arpl_pkg::ARP_FRAME_TYPE, bound_ip[DEPTH-1], '1, bound_ip[0], 48'h3);
		send_frame(arpl_pkg::ARP_FRAME_TYPE, 32'h7f00_0003, 48'h4, bound_ip[DEPTH-1],
				48'h5);
		send_frame(arpl_pkg::ARP_FRAME_TYPE, 32'h7f00_0004, '0, 32'h7f00_0004, 48'h6);
		send_frame(16'h0800, 32'h7f00_0005, 48'h7, bound_ip[1], 48'h8);
		settle();
	endtask

	// wide pool and fresh addresses on the full table: updates and drops
	task automatic test_full_table();
		for (int i = 0; i < 950; i++)
			random_frame(POOL_SIZE, 15);
		settle();
	endtask

	// ---------------------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------------------

	function automatic void check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d",
						$time, name, want_v, got_v);
		end
	endfunction

	// a result is taken at the edge that ends its done cycle
	always @(posedge clk) begin : result_check
		learn_result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: result with no frame outstanding, expected none, actual %0d/%0d",
							$time, sender_status, target_status);
			end else begin
				want = pending_results.pop_front();
				check_field("sender_status", 32'(want.sender_status), 32'(sender_status));
				check_field("sender_slot", 32'(want.sender_slot), 32'(sender_slot));
				check_field("target_status", 32'(want.target_status), 32'(target_status));
				check_field("target_slot", 32'(want.target_slot), 32'(target_slot));
				check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
					$time, cycle_count, pending_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		bound_count = 0;
		ip_pool[0]  = '0;
		ip_pool[1]  = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			ip_pool[i] = $urandom();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_growing_table();
		test_back_to_back();
		test_table_limit();
		test_full_table();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			fail_count++;
			$display("%0t: frames left without a result, expected 0, actual %0d",
					$time, pending_results.size());
		end

		$display("sent %0d frames, %0d results compared, table ended with %0d entries",
				frames_sent, results_seen, bound_count);
		$display("pair outcomes: %0d ignored, %0d updated, %0d added, %0d dropped",
				status_tally[int'(arpl_pkg::ST_IGNORED)],
				status_tally[int'(arpl_pkg::ST_UPDATED)],
				status_tally[int'(arpl_pkg::ST_ADDED)],
				status_tally[int'(arpl_pkg::ST_FULL)]);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== arp_ip_mac_learning_table.f =====
rtl/core/arpl_pkg.sv
rtl/core/arpl_ctrl.sv
rtl/core/arpl_dpath.sv
rtl/core/arp_ip_mac_learning_table.sv
rtl/core/arpl_checker.sv
test/tb_top.sv
